@@ rtl/pfer_pkg.sv @@
// Shared types, constants and codes for the PCM frame expand resampler.
`default_nettype none

package pfer_pkg;

    // Width of the phase accumulator; one run ends when it wraps.
    localparam int PHASE_BITS = 10;
    localparam int PHASE_FULL = 1 << PHASE_BITS;
    localparam int INC_W      = PHASE_BITS + 1;

    // Configuration register widths and the smallest increment allowed.
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int INC_FLOOR_MIN = 16;
    localparam int INC_FLOOR     = ((PHASE_FULL >> 6) > INC_FLOOR_MIN) ?
                                   (PHASE_FULL >> 6) : INC_FLOOR_MIN;
    localparam int CMP_W         = (INC_W > CFG_DATA_W) ? INC_W : CFG_DATA_W;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FORMAT_MODE     = 2'd0,
        CFG_PHASE_INCREMENT = 2'd1,
        CFG_SPARE_2         = 2'd2,
        CFG_SPARE_3         = 2'd3
    } t_cfg_index;

    // Source frame formats.
    typedef enum logic [1:0] {
        FMT_MONO16   = 2'd0,
        FMT_STEREO16 = 2'd1,
        FMT_MONO8    = 2'd2,
        FMT_STEREO8  = 2'd3
    } t_format;

    // One expanded frame waiting to be repeated.
    typedef struct packed {
        logic [15:0]      left;
        logic [15:0]      right;
        logic [INC_W-1:0] inc;
    } t_frame;

    // Queue status seen by the back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Back sequencer states.
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

@@ rtl/pfer_front.sv @@
// Front: configuration registers, frame acceptance and stereo expansion.
`default_nettype none

module pfer_front
    import pfer_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_push,
    input  wire logic [31:0]            i_frame_data,
    input  wire logic                   i_q_full,
    output logic                        o_q_write,
    output t_frame                      o_q_data
);

    t_format               r_format;
    logic [CFG_DATA_W-1:0] r_inc;
    logic [CMP_W-1:0]      inc_ext;
    logic [CMP_W-1:0]      inc_sat;
    logic [15:0]           left;
    logic [15:0]           right;

    assign o_cfg_ready = 1'b1;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_STEREO16;
            r_inc    <= CFG_DATA_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FORMAT_MODE:     r_format <= t_format'(i_cfg_data[1:0]);
                CFG_PHASE_INCREMENT: r_inc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the increment to the range that bounds a run.
    always_comb begin
        inc_ext = CMP_W'(r_inc);
        if (inc_ext < CMP_W'(INC_FLOOR)) begin
            inc_sat = CMP_W'(INC_FLOOR);
        end else if (inc_ext > CMP_W'(PHASE_FULL)) begin
            inc_sat = CMP_W'(PHASE_FULL);
        end else begin
            inc_sat = inc_ext;
        end
    end

    // Expand the frame to a 16-bit stereo pair.
    always_comb begin
        unique case (r_format)
            FMT_MONO16: begin
                left  = i_frame_data[15:0];
                right = i_frame_data[15:0];
            end
            FMT_STEREO16: begin
                left  = i_frame_data[15:0];
                right = i_frame_data[31:16];
            end
            FMT_MONO8: begin
                left  = {i_frame_data[7:0], 8'h00};
                right = {i_frame_data[7:0], 8'h00};
            end
            default: begin
                left  = {i_frame_data[7:0], 8'h00};
                right = {i_frame_data[15:8], 8'h00};
            end
        endcase
    end

    assign o_q_write      = i_push && !i_q_full;
    assign o_q_data.left  = left;
    assign o_q_data.right = right;
    assign o_q_data.inc   = INC_W'(inc_sat);

endmodule

`default_nettype wire

@@ rtl/pfer_fifo.sv @@
// Short queue of expanded frames between the front and the back.
`default_nettype none

module pfer_fifo
    import pfer_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_write,
    input  wire t_frame i_data,
    input  wire logic   i_read,
    output t_frame      o_data,
    output t_q_status   o_status
);

    t_frame            r_mem [QDEPTH];
    logic [QA_W-1:0]   r_wr_ptr;
    logic [QA_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_count;
    logic              do_write;
    logic              do_read;

    assign o_status.empty = (r_count == QC_W'(0));
    assign o_status.full  = (r_count == QC_W'(QDEPTH));
    assign do_write       = i_write && !o_status.full;
    assign do_read        = i_read && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_write) begin
                r_wr_ptr <= (r_wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QA_W'(1);
            end
            if (do_read) begin
                r_rd_ptr <= (r_rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QA_W'(1);
            end
            if (do_write && !do_read) begin
                r_count <= r_count + QC_W'(1);
            end else if (do_read && !do_write) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfer_back.sv @@
// Back: phase accumulator that repeats each frame as a run of output pairs.
`default_nettype none

module pfer_back
    import pfer_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_frame    i_q_data,
    input  wire t_q_status i_q_status,
    output logic           o_q_read,
    input  wire logic      i_pop,
    output logic           o_empty,
    output logic [15:0]    o_left_sample,
    output logic [15:0]    o_right_sample,
    output logic           o_last_of_run
);

    t_back_state           r_state;
    t_back_state           n_state;
    t_frame                r_frame;
    logic [PHASE_BITS-1:0] r_acc;
    logic                  r_out_valid;
    logic [15:0]           r_left;
    logic [15:0]           r_right;
    logic                  r_last;
    logic [INC_W-1:0]      sum;
    logic                  last;
    logic                  emit;
    logic                  load;

    // The wrap bit of the sum marks the final pair of the run.
    assign sum  = {1'b0, r_acc} + r_frame.inc;
    assign last = sum[PHASE_BITS];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_q_status.empty) n_state = BK_RUN;
            BK_RUN:  if (emit && last)       n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        load = 1'b0;
        emit = 1'b0;
        unique case (r_state)
            BK_IDLE: load = !i_q_status.empty;
            BK_RUN:  emit = !r_out_valid || i_pop;
            default: ;
        endcase
    end

    assign o_q_read = load;

    // Control state: sequencer, accumulator and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_acc       <= sum[PHASE_BITS-1:0];
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame being repeated and the output beat.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= i_q_data;
        end
        if (emit) begin
            r_left  <= r_frame.left;
            r_right <= r_frame.right;
            r_last  <= last;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_left_sample  = r_left;
    assign o_right_sample = r_right;
    assign o_last_of_run  = r_last;

endmodule

`default_nettype wire

@@ rtl/pcm_frame_expand_resampler_unit.sv @@
// Top level of the PCM frame expand resampler.
//
//   Channel   Ports                                   Handshake
//   frames    push, full, i_frame_data                 beat when push and not full
//   pairs     pop, empty, o_left/right_sample, last    beat when pop and not empty
//   config    i_cfg_valid, o_cfg_ready, index, data    beat when valid and ready
//
// Each frame gives a run of 1 to 64 pairs from the phase accumulator in the back,
// one pair a cycle while the consumer keeps taking them, and the back loads the
// next frame from the queue in its idle state between runs. The run length is set by
// the increment and the accumulator left by the previous frame.
// Reset is synchronous; the accumulator clears to zero and the queue empties.
// A held pair stalls the back only; the front takes frames until the queue is full.
`default_nettype none

module pcm_frame_expand_resampler_unit
    import pfer_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [31:0]            i_frame_data,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [15:0]          o_left_sample,
    output logic signed [15:0]          o_right_sample,
    output logic                        o_last_of_run
);

    t_frame    q_wr_data;
    t_frame    q_rd_data;
    t_q_status q_status;
    logic      q_write;
    logic      q_read;
    logic [15:0] left;
    logic [15:0] right;

    pfer_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_frame_data (i_frame_data),
        .i_q_full     (q_status.full),
        .o_q_write    (q_write),
        .o_q_data     (q_wr_data)
    );

    pfer_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (q_write),
        .i_data   (q_wr_data),
        .i_read   (q_read),
        .o_data   (q_rd_data),
        .o_status (q_status)
    );

    pfer_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_rd_data),
        .i_q_status     (q_status),
        .o_q_read       (q_read),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_left_sample  (left),
        .o_right_sample (right),
        .o_last_of_run  (o_last_of_run)
    );

    assign full           = q_status.full;
    assign o_left_sample  = signed'(left);
    assign o_right_sample = signed'(right);

endmodule

`default_nettype wire

@@ rtl/pfer_checker.sv @@
// Port-level checks for the PCM frame expand resampler, bound to the top level.
`default_nettype none

module pfer_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic signed [15:0] o_left_sample,
    input  wire logic signed [15:0] o_right_sample,
    input  wire logic               o_last_of_run
);

    // Reset leaves no pair waiting and room for frames.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("pfer: reset did not clear the queues");

    // A pair held back by the consumer stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_left_sample)
            && $stable(o_right_sample) && $stable(o_last_of_run))
        else $error("pfer: waiting pair changed");

    // Taking a pair that is not the last of its run brings the next one at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last_of_run |=> !empty)
        else $error("pfer: run broke off before its last pair");

    // The frame queue fills only after an accepted frame.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("pfer: queue became full without a frame beat");

endmodule

bind pcm_frame_expand_resampler_unit pfer_checker u_pfer_checker (.*);

`default_nettype wire

@@ sim/pcm_frame_expand_resampler_unit_test.sv @@
// Self-checking testbench for the PCM frame expand resampler unit.
`default_nettype none

module pcm_frame_expand_resampler_unit_test;
    import pfer_pkg::*;

    // Longest run of pairs one frame can give, and the run-out allowances.
    localparam int RUN_MAX     = 64;
    localparam int DRAIN_PAD   = 8;
    localparam int DRAIN_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 30;

    // One expected output pair.
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } t_pair;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [31:0]            i_frame_data = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic signed [15:0]     o_left_sample;
    logic signed [15:0]     o_right_sample;
    logic                   o_last_of_run;

    // Shadow copy of the block's registers and accumulator.
    t_format                fmt_shadow;
    logic [CFG_DATA_W-1:0]  inc_shadow;
    logic [PHASE_BITS-1:0]  acc_shadow;

    // Pairs predicted but not yet seen on the output.
    t_pair pending_pairs[$];

    // Idling controls and the long receiver hold-off.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    pcm_frame_expand_resampler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_frame_data   (i_frame_data),
        .empty          (empty),
        .pop            (pop),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample),
        .o_last_of_run  (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // Give up if the run hangs.
    initial begin
        #2400000;
        $display("CHECK FAILED");
        $finish;
    end

    // Expand one frame and repeat it under the phase accumulator.
    function automatic void predict_run(input logic [31:0] frame);
        logic [15:0] left;
        logic [15:0] right;
        int          step;
        int          phase;
        t_pair       pair;
        case (fmt_shadow)
            FMT_MONO16: begin
                left  = frame[15:0];
                right = frame[15:0];
            end
            FMT_STEREO16: begin
                left  = frame[15:0];
                right = frame[31:16];
            end
            FMT_MONO8: begin
                left  = {frame[7:0], 8'h00};
                right = {frame[7:0], 8'h00};
            end
            default: begin
                left  = {frame[7:0], 8'h00};
                right = {frame[15:8], 8'h00};
            end
        endcase
        // The step is clamped to the range that keeps a run within 64 pairs.
        step = int'(inc_shadow);
        if (step < INC_FLOOR) step = INC_FLOOR;
        if (step > PHASE_FULL) step = PHASE_FULL;
        phase = int'(acc_shadow);
        for (int n = 0; n < RUN_MAX; n++) begin
            phase      = phase + step;
            pair.left  = left;
            pair.right = right;
            pair.last  = (phase >= PHASE_FULL);
            pending_pairs.push_back(pair);
            if (pair.last) begin
                phase = phase - PHASE_FULL;
                break;
            end
        end
        acc_shadow = phase[PHASE_BITS-1:0];
    endfunction

    // Offer one frame, with random idle cycles first, until a beat takes it.
    task automatic send_frame(input logic [31:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_frame_data <= frame;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_run(frame);
    endtask

    // Wait, within a limit, until every predicted pair has been taken.
    task automatic drain_pairs();
        for (int n = 0; n < DRAIN_LIMIT && pending_pairs.size() != 0; n++)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Write one register once the block has gone idle.
    task automatic write_reg(input t_cfg_index index, input logic [CFG_DATA_W-1:0] value);
        push <= 1'b0;
        drain_pairs();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_FORMAT_MODE) begin
            fmt_shadow = t_format'(value[1:0]);
        end else if (index == CFG_PHASE_INCREMENT) begin
            inc_shadow = value;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Frames straight after reset use stereo 16-bit with one pair per frame.
    task automatic test_reset_defaults();
        send_frame(32'h8000_7FFF);
        send_frame(32'h7FFF_8000);
    endtask

    // Every format with sign and byte extremes in each lane.
    task automatic test_formats();
        logic [31:0] frames[3];
        frames = '{32'hFFFF_FFFF, 32'h7FFF_8000, 32'h8000_807F};
        write_reg(CFG_PHASE_INCREMENT, CFG_DATA_W'(512));
        for (int f = 0; f < 4; f++) begin
            write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(f));
            foreach (frames[k]) send_frame(frames[k]);
        end
    endtask

    // Increments below the floor, at both limits, odd, and above full scale.
    task automatic test_increment_limits();
        logic [CFG_DATA_W-1:0] steps[7];
        steps = '{11'd0, 11'd15, 11'd16, 11'd17, 11'd1024, 11'd1025, 11'd2047};
        write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(FMT_MONO16));
        foreach (steps[k]) begin
            write_reg(CFG_PHASE_INCREMENT, steps[k]);
            send_frame($urandom());
            if (steps[k] == 11'd17) send_frame($urandom());
        end
    endtask

    // Writes to the unused indexes must leave both registers alone.
    task automatic test_spare_indexes();
        write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(FMT_STEREO8));
        write_reg(CFG_PHASE_INCREMENT, CFG_DATA_W'(700));
        write_reg(CFG_SPARE_2, 11'h7FF);
        write_reg(CFG_SPARE_3, 11'h000);
        send_frame(32'h0000_80FF);
        send_frame($urandom());
    endtask

    // The receiver holds off while long runs pile up and the input fills.
    task automatic test_input_backpressure();
        set_idling(0, 0);
        write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(FMT_STEREO16));
        write_reg(CFG_PHASE_INCREMENT, CFG_DATA_W'(INC_FLOOR));
        hold_trigger <= hold_trigger + 1;
        for (int k = 0; k < 16; k++) send_frame($urandom());
    endtask

    // Random register settings, weighted so the clamps are hit now and then.
    task automatic pick_random_config();
        logic [CFG_DATA_W-1:0] step;
        int                    sel;
        sel = $urandom_range(7);
        if (sel == 0)      step = CFG_DATA_W'($urandom_range(15));
        else if (sel == 1) step = CFG_DATA_W'($urandom_range(2047, 1025));
        else if (sel == 2) step = CFG_DATA_W'($urandom_range(63, 16));
        else               step = CFG_DATA_W'($urandom_range(1024, 64));
        if ($urandom_range(1) == 1) begin
            write_reg(CFG_FORMAT_MODE, CFG_DATA_W'($urandom_range(3)));
            write_reg(CFG_PHASE_INCREMENT, step);
        end else begin
            write_reg(CFG_PHASE_INCREMENT, step);
            write_reg(CFG_FORMAT_MODE, CFG_DATA_W'($urandom_range(3)));
        end
        if ($urandom_range(3) == 0)
            write_reg(t_cfg_index'($urandom_range(3, 2)), CFG_DATA_W'($urandom_range(2047)));
    endtask

    // Random frames under each idling pattern, two settings per pattern.
    task automatic test_random_traffic();
        int send_pcts[4];
        int recv_pcts[4];
        send_pcts = '{0, 75, 0, 33};
        recv_pcts = '{0, 0, 75, 33};
        for (int m = 0; m < 4; m++) begin
            set_idling(send_pcts[m], recv_pcts[m]);
            for (int c = 0; c < 2; c++) begin
                pick_random_config();
                for (int k = 0; k < PHASE_ITEMS; k++) send_frame($urandom());
            end
        end
    endtask

    // Long receiver hold-off: a new request restarts the cycle count.
    always @(posedge i_clk) begin : hold_counter
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check every pair beat against the oldest prediction, then pick the next pop.
    always @(posedge i_clk) begin : pair_checker
        t_pair want;
        if (pop && !empty) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: pair with none expected, left %0d right %0d last %0b",
                         $time, o_left_sample, o_right_sample, o_last_of_run);
                mismatch_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_left_sample !== want.left) begin
                    $display("%0t: left_sample expected %0d actual %0d",
                             $time, want.left, o_left_sample);
                    mismatch_count++;
                end
                if (o_right_sample !== want.right) begin
                    $display("%0t: right_sample expected %0d actual %0d",
                             $time, want.right, o_right_sample);
                    mismatch_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Test sequence.
    initial begin
        fmt_shadow = FMT_STEREO16;
        inc_shadow = CFG_DATA_W'(PHASE_FULL);
        acc_shadow = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_formats();
        test_increment_limits();
        test_spare_indexes();
        test_input_backpressure();
        test_random_traffic();

        push <= 1'b0;
        set_idling(0, 0);
        drain_pairs();
        if (pending_pairs.size() != 0)
            $display("%0t: %0d expected pairs never arrived", $time, pending_pairs.size());
        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/pfer_pkg.sv
rtl/pfer_front.sv
rtl/pfer_fifo.sv
rtl/pfer_back.sv
rtl/pcm_frame_expand_resampler_unit.sv
rtl/pfer_checker.sv
sim/pcm_frame_expand_resampler_unit_test.sv
